/* hw/rtl/gds_pkg.sv */
// Shared types, constants and calendar helper functions for the Gregorian
// date stepper. No dependencies.
package gds_pkg;

  localparam int NumStages = 5;
  localparam int YearW     = 14;
  localparam int MonthW    = 4;
  localparam int DayW      = 5;
  localparam int WdayW     = 3;
  localparam int McodeW    = 6;
  localparam int Q100W     = 8;

  localparam logic [YearW-1:0]  YearMin   = 14'd1;
  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthMar  = 4'd3;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [DayW-1:0]   DayFirst  = 5'd1;

  // Direction codes
  localparam logic ActNext = 1'b0;
  localparam logic ActPrev = 1'b1;

  // 2^19 / 100 rounded up; exact floor quotient for every 14-bit value
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int          Recip100Shift = 19;

  typedef logic [NumStages-1:0] stage_vec_t;

  // Item handed from the date stage to the weekday stage
  typedef struct packed {
    logic              ok;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  wyear;   // year used by the weekday sum
    logic [McodeW-1:0] mcode;   // (13*m+8)/5 with Jan/Feb as months 13/14
  } date_item_t;

  // Floor of y / 100 by reciprocal multiply
  function automatic logic [Q100W-1:0] div100(input logic [YearW-1:0] y);
    logic [26:0] prod;
    prod = {13'd0, y} * {14'd0, Recip100};
    return prod[Recip100Shift +: Q100W];
  endfunction

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Month term of the weekday sum
  function automatic logic [McodeW-1:0] month_code(input logic [MonthW-1:0] m);
    logic [McodeW-1:0] c;
    case (m)
      4'd1:    c = 6'd35;
      4'd2:    c = 6'd38;
      4'd3:    c = 6'd9;
      4'd4:    c = 6'd12;
      4'd5:    c = 6'd14;
      4'd6:    c = 6'd17;
      4'd7:    c = 6'd19;
      4'd8:    c = 6'd22;
      4'd9:    c = 6'd25;
      4'd10:   c = 6'd27;
      4'd11:   c = 6'd30;
      4'd12:   c = 6'd32;
      default: c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/gds_date_stage.sv */
// Stages 1 and 2: year/100 quotient, then validation and the one-day step.
// Depends on gds_pkg.
module gds_date_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      action,
  input  logic [gds_pkg::YearW-1:0] in_year,
  input  logic [gds_pkg::MonthW-1:0] in_month,
  input  logic [gds_pkg::DayW-1:0]  in_day,
  input  logic [1:0]                hold,
  output logic [1:0]                vld,
  output gds_pkg::date_item_t       item
);
  import gds_pkg::*;

  // Stage 1 registers
  logic              act1;
  logic [YearW-1:0]  y1;
  logic [MonthW-1:0] m1;
  logic [DayW-1:0]   d1;
  logic [Q100W-1:0]  q1;

  logic [YearW-1:0]  r100_full;
  logic [6:0]        r100;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic              valid_in;
  logic [YearW-1:0]  ny;
  logic [MonthW-1:0] nm;
  logic [DayW-1:0]   nd;
  logic              ok_next;
  date_item_t        item_next;

  // Advance the valid bits of both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (!hold[0]) vld[0] <= in_valid;
      if (!hold[1]) vld[1] <= vld[0];
    end
  end

  // Capture the input item and its year quotient
  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      act1 <= action;
      y1   <= in_year;
      m1   <= in_month;
      d1   <= in_day;
      q1   <= div100(in_year);
    end
  end

  // Leap rule and month length
  always_comb begin
    r100_full = y1 - ({6'd0, q1} * 14'd100);
    r100      = r100_full[6:0];
    leap      = (y1[1:0] == 2'b00) && ((r100 != 7'd0) || (q1[1:0] == 2'b00));
    mlen      = month_len(m1, leap);
    valid_in  = (y1 >= YearMin) && (y1 <= YearMax) && (m1 >= MonthJan) &&
                (m1 <= MonthDec) && (d1 >= DayFirst) && (d1 <= mlen);
  end

  // Step one day forward or back
  always_comb begin
    ny = y1;
    nm = m1;
    nd = d1;
    if (act1 == ActNext) begin
      if (d1 == mlen) begin
        nd = DayFirst;
        if (m1 == MonthDec) begin
          nm = MonthJan;
          ny = y1 + 14'd1;
        end else begin
          nm = m1 + 4'd1;
        end
      end else begin
        nd = d1 + 5'd1;
      end
    end else begin
      if (d1 == DayFirst) begin
        if (m1 == MonthJan) begin
          nm = MonthDec;
          ny = y1 - 14'd1;
        end else begin
          nm = m1 - 4'd1;
        end
        // year only changes into December, where leap does not matter
        nd = month_len(nm, leap);
      end else begin
        nd = d1 - 5'd1;
      end
    end
    ok_next = valid_in && (ny >= YearMin) && (ny <= YearMax);

    item_next.ok    = ok_next;
    item_next.year  = ok_next ? ny : y1;
    item_next.month = ok_next ? nm : m1;
    item_next.day   = ok_next ? nd : d1;
    if (ok_next && (nm < MonthMar)) begin
      item_next.wyear = ny - 14'd1;
    end else if (ok_next) begin
      item_next.wyear = ny;
    end else begin
      item_next.wyear = '0;
    end
    item_next.mcode = month_code(nm);
  end

  always_ff @(posedge clk) begin
    if (!hold[1]) begin
      item <= item_next;
    end
  end

endmodule

/* hw/rtl/gds_weekday_stage.sv */
// Stages 3 to 5: weekday sum of the stepped date and its reduction mod 7.
// Depends on gds_pkg.
module gds_weekday_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  input  gds_pkg::date_item_t        up_item,
  input  logic [2:0]                 hold,
  output logic [2:0]                 vld,
  output logic                       ok,
  output logic [gds_pkg::YearW-1:0]  out_year,
  output logic [gds_pkg::MonthW-1:0] out_month,
  output logic [gds_pkg::DayW-1:0]   out_day,
  output logic [gds_pkg::WdayW-1:0]  weekday
);
  import gds_pkg::*;

  localparam int SumW = 15;

  // Stage 3 registers
  date_item_t       it3;
  logic [Q100W-1:0] q3;
  // Stage 4 registers
  logic              ok4;
  logic [YearW-1:0]  y4;
  logic [MonthW-1:0] m4;
  logic [DayW-1:0]   d4;
  logic [SumW-1:0]   sum4;

  logic [SumW-1:0] sum_next;
  logic [5:0]      fold1;
  logic [3:0]      fold2;
  logic [WdayW-1:0] wd_next;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (!hold[0]) vld[0] <= up_valid;
      if (!hold[1]) vld[1] <= vld[0];
      if (!hold[2]) vld[2] <= vld[1];
    end
  end

  // Stage 3: century count of the weekday year
  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      it3 <= up_item;
      q3  <= div100(up_item.wyear);
    end
  end

  // Stage 4: weekday sum
  always_comb begin
    sum_next = {1'b0, it3.wyear} + {3'd0, it3.wyear[YearW-1:2]}
             - {7'd0, q3} + {9'd0, q3[Q100W-1:2]}
             + {9'd0, it3.mcode} + {10'd0, it3.day};
  end

  always_ff @(posedge clk) begin
    if (!hold[1]) begin
      ok4  <= it3.ok;
      y4   <= it3.year;
      m4   <= it3.month;
      d4   <= it3.day;
      sum4 <= sum_next;
    end
  end

  // Stage 5: mod 7 by folding octal digits (8 = 1 mod 7)
  always_comb begin
    fold1 = {3'd0, sum4[2:0]} + {3'd0, sum4[5:3]} + {3'd0, sum4[8:6]}
          + {3'd0, sum4[11:9]} + {3'd0, sum4[14:12]};
    fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
    if (fold2 >= 4'd7) begin
      wd_next = WdayW'(fold2 - 4'd7);
    end else begin
      wd_next = fold2[WdayW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[2]) begin
      ok        <= ok4;
      out_year  <= y4;
      out_month <= m4;
      out_day   <= d4;
      weekday   <= ok4 ? wd_next : '0;
    end
  end

endmodule

/* hw/rtl/gregorian_date_stepper_unit.sv */
// Top level of the Gregorian date stepper: five-stage pipeline and its
// stall chain. Depends on gds_pkg, gds_date_stage and gds_weekday_stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  input   | in_valid  | in_stall  | action, in_year, in_month, in_day
//  output  | out_valid | out_stall | ok, out_year, out_month, out_day, weekday
//
// One item enters per cycle while in_stall is low; results leave in input order.
// The five register stages are: year/100, validate and step,
// year/100 of the weekday year, weekday sum, mod 7 and output register.
// Reset clears the stage valid bits only.
// A stalled output holds the last stage; earlier stages keep moving into
// empty slots, so bubbles close up and in_stall rises only when all are full.
module gregorian_date_stepper_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [gds_pkg::YearW-1:0]  in_year,
  input  logic [gds_pkg::MonthW-1:0] in_month,
  input  logic [gds_pkg::DayW-1:0]   in_day,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       ok,
  output logic [gds_pkg::YearW-1:0]  out_year,
  output logic [gds_pkg::MonthW-1:0] out_month,
  output logic [gds_pkg::DayW-1:0]   out_day,
  output logic [gds_pkg::WdayW-1:0]  weekday
);
  import gds_pkg::*;

  stage_vec_t v;
  stage_vec_t hold;
  date_item_t mid_item;

  // Hold a stage when it is full and the one after it holds
  always_comb begin
    hold[NumStages-1] = v[NumStages-1] && out_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      hold[k] = v[k] && hold[k+1];
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = v[NumStages-1];

  gds_date_stage u_date (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_year  (in_year),
    .in_month (in_month),
    .in_day   (in_day),
    .hold     (hold[1:0]),
    .vld      (v[1:0]),
    .item     (mid_item)
  );

  gds_weekday_stage u_wday (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (v[1]),
    .up_item   (mid_item),
    .hold      (hold[4:2]),
    .vld       (v[4:2]),
    .ok        (ok),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .weekday   (weekday)
  );

  // A valid result names a real month and weekday
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> (out_month >= MonthJan) && (out_month <= MonthDec) &&
                        (weekday <= 3'd6))
    else $error("ok result with bad month or weekday");

  // A rejected item carries weekday zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (weekday == '0))
    else $error("rejected item with nonzero weekday");

  // Input stalls only behind a stalled, full output
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && (v == '1))
    else $error("input stalled with room in the pipe");

  // A stalled result keeps its year, day and weekday
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_year) &&
                               $stable(out_day) && $stable(weekday))
    else $error("stalled result changed");

endmodule

/* test/gregorian_date_stepper_unit_test.sv */
// Self-checking testbench for gregorian_date_stepper_unit: drives dates with random idling
// on both channels and compares every result against a calendar predictor.
// Depends on gds_pkg and the stepper RTL.
`timescale 1ns / 1ps

module gregorian_date_stepper_unit_test;
  import gds_pkg::*;

  localparam int RandomItems = 1100;
  localparam int IdleLimit   = 2000;
  localparam int MaxReports  = 60;

  typedef struct packed {
    logic              ok;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [WdayW-1:0]  wday;
  } date_result_t;

  // Calendar predictor and the queue of dates still owed by the block
  class date_scoreboard;
    date_result_t owed_q[$];
    int mismatches;
    int checked;
    int valid_seen;

    function new();
      mismatches = 0;
      checked    = 0;
      valid_seen = 0;
    endfunction

    function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in(int y, int m);
      int n;
      case (m)
        1, 3, 5, 7, 8, 10, 12: n = 31;
        4, 6, 9, 11:           n = 30;
        2:                     n = is_leap(y) ? 29 : 28;
        default:               n = 0;
      endcase
      return n;
    endfunction

    // Zeller-style sum; Jan and Feb count as months 13 and 14 of the prior year
    function int weekday_of(int y, int m, int d);
      int yy;
      int mm;
      yy = y;
      mm = m;
      if (mm < 3) begin
        yy = yy - 1;
        mm = mm + 12;
      end
      return (yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + d) % 7;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Predict the stepped date for one accepted item
    function void note_input(logic act, logic [YearW-1:0] yin, logic [MonthW-1:0] min,
                             logic [DayW-1:0] din);
      int y;
      int m;
      int d;
      int ny;
      int nm;
      int nd;
      bit good;
      date_result_t r;
      y  = int'(yin);
      m  = int'(min);
      d  = int'(din);
      ny = y;
      nm = m;
      nd = d;
      good = (y >= 1) && (y <= 9999) && (m >= 1) && (m <= 12) &&
             (d >= 1) && (d <= days_in(y, m));
      if (good) begin
        if (act == ActNext) begin
          if (d == days_in(y, m)) begin
            nd = 1;
            if (m == 12) begin
              nm = 1;
              ny = y + 1;
            end else begin
              nm = m + 1;
            end
          end else begin
            nd = d + 1;
          end
        end else begin
          if (d == 1) begin
            if (m == 1) begin
              nm = 12;
              ny = y - 1;
            end else begin
              nm = m - 1;
            end
            nd = days_in(ny, nm);
          end else begin
            nd = d - 1;
          end
        end
        if (ny < 1 || ny > 9999) good = 1'b0;
      end
      if (good) begin
        r.ok    = 1'b1;
        r.year  = ny[YearW-1:0];
        r.month = nm[MonthW-1:0];
        r.day   = nd[DayW-1:0];
        r.wday  = WdayW'(weekday_of(ny, nm, nd));
      end else begin
        r.ok    = 1'b0;
        r.year  = yin;
        r.month = min;
        r.day   = din;
        r.wday  = '0;
      end
      owed_q.push_back(r);
    endfunction

    function void report(string field, int exp_v, int act_v);
      mismatches++;
      if (mismatches <= MaxReports)
        $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(date_result_t got);
      date_result_t exp_r;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $error("result with no item outstanding: year %0d month %0d day %0d",
                 got.year, got.month, got.day);
        return;
      end
      exp_r = owed_q.pop_front();
      checked++;
      if (exp_r.ok) valid_seen++;
      if (got.ok !== exp_r.ok)
        report("ok", int'(exp_r.ok), int'(got.ok));
      if (got.year !== exp_r.year)
        report("out_year", int'(exp_r.year), int'(got.year));
      if (got.month !== exp_r.month)
        report("out_month", int'(exp_r.month), int'(got.month));
      if (got.day !== exp_r.day)
        report("out_day", int'(exp_r.day), int'(got.day));
      if (got.wday !== exp_r.wday)
        report("weekday", int'(exp_r.wday), int'(got.wday));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [YearW-1:0]   in_year;
  logic [MonthW-1:0]  in_month;
  logic [DayW-1:0]    in_day;
  logic               out_valid;
  logic               out_stall;
  logic               ok;
  logic [YearW-1:0]   out_year;
  logic [MonthW-1:0]  out_month;
  logic [DayW-1:0]    out_day;
  logic [WdayW-1:0]   weekday;

  date_scoreboard sb;
  bit             steady;
  int             sent;
  int             idle_cycles;

  gregorian_date_stepper_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .weekday   (weekday)
  );

  always #10 clk = ~clk;

  // Abort when neither channel moves an item for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Idle cycles before the next item; none during the steady stretch
  function automatic int draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Present one date and hold it until accepted
  task automatic send_date(input logic a, input logic [YearW-1:0] y,
                           input logic [MonthW-1:0] m, input logic [DayW-1:0] d);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    in_year  <= y;
    in_month <= m;
    in_day   <= d;
    do @(posedge clk); while (in_stall);
    sb.note_input(a, y, m, d);
    sent++;
  endtask

  // Mostly well-formed dates near month, year and range boundaries, plus noise
  task automatic send_random_date();
    int corner_years[14] = '{1, 2, 99, 100, 101, 399, 400, 401, 1899, 1900, 2000, 2100,
                             9998, 9999};
    int kind;
    int y;
    int m;
    int d;
    int len;
    logic a;
    kind = $urandom_range(0, 99);
    a    = 1'($urandom_range(0, 1));
    if (kind < 70) begin
      if (kind < 50) begin
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
      end else begin
        y = corner_years[$urandom_range(0, 13)];
        m = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 12;
      end
      len = sb.days_in(y, m);
      case ($urandom_range(0, 3))
        0:       d = 1;
        1:       d = len;
        default: d = $urandom_range(1, len);
      endcase
    end else if (kind < 85) begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      len = sb.days_in(y, m);
      case ($urandom_range(0, 3))
        0: d = 0;
        1: d = len + 1;
        2: d = 31;
        default: begin
          d = $urandom_range(0, 31);
          m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
        end
      endcase
    end else begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    send_date(a, y[YearW-1:0], m[MonthW-1:0], d[DayW-1:0]);
  endtask

  // Receive results with random stall and check each one
  initial begin
    int hold;
    date_result_t got;
    do @(posedge clk); while (rst);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.ok    = ok;
      got.year  = out_year;
      got.month = out_month;
      got.day   = out_day;
      got.wday  = weekday;
      sb.check_result(got);
    end
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ActNext;
    in_year   = '0;
    in_month  = '0;
    in_day    = '0;
    out_stall = 1'b0;
    steady    = 1'b0;
    sent      = 0;
    sb        = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Range ends: stepping past 9999-12-31 or before 0001-01-01 fails
    send_date(ActNext, 14'd9999, 4'd12, 5'd31);
    send_date(ActPrev, 14'd1, 4'd1, 5'd1);
    send_date(ActPrev, 14'd9999, 4'd12, 5'd31);
    send_date(ActNext, 14'd9998, 4'd12, 5'd31);
    // January of year 1 puts year 0 into the weekday sum
    send_date(ActNext, 14'd1, 4'd1, 5'd1);
    send_date(ActPrev, 14'd1, 4'd1, 5'd2);
    send_date(ActPrev, 14'd1, 4'd3, 5'd1);
    // Leap rule: every 4th year, not every 100th, but every 400th
    send_date(ActNext, 14'd2000, 4'd2, 5'd28);
    send_date(ActNext, 14'd2000, 4'd2, 5'd29);
    send_date(ActNext, 14'd1900, 4'd2, 5'd28);
    send_date(ActNext, 14'd1900, 4'd2, 5'd29);
    send_date(ActPrev, 14'd2024, 4'd3, 5'd1);
    send_date(ActPrev, 14'd2023, 4'd3, 5'd1);
    send_date(ActPrev, 14'd2100, 4'd3, 5'd1);
    // Year rollover both ways
    send_date(ActPrev, 14'd2024, 4'd1, 5'd1);
    send_date(ActNext, 14'd2024, 4'd12, 5'd31);
    // Invalid fields: month and day below one, beyond the month, year out of range
    send_date(ActNext, 14'd2024, 4'd0, 5'd10);
    send_date(ActPrev, 14'd2024, 4'd13, 5'd10);
    send_date(ActNext, 14'd2024, 4'd15, 5'd31);
    send_date(ActPrev, 14'd2024, 4'd5, 5'd0);
    send_date(ActNext, 14'd2024, 4'd4, 5'd31);
    send_date(ActNext, 14'd0, 4'd6, 5'd15);
    send_date(ActPrev, 14'd10000, 4'd6, 5'd15);
    send_date(ActPrev, 14'h3FFF, 4'hF, 5'h1F);

    for (int i = 0; i < RandomItems; i++) begin
      steady = (i >= 300 && i < 400);
      // Let the pipeline drain completely once
      if (i == 600) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_random_date();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (NumStages * 4) @(posedge clk);

    $display("Stepped %0d dates forward and back, %0d results checked, %0d valid dates.",
             sent, sb.checked, sb.valid_seen);
    $display("Covered leap years, range ends, invalid fields and random idling.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gds_pkg.sv
hw/rtl/gds_date_stage.sv
hw/rtl/gds_weekday_stage.sv
hw/rtl/gregorian_date_stepper_unit.sv
test/gregorian_date_stepper_unit_test.sv
